// ===== rtl/nnir_pkg.sv =====
// nnir_pkg: shared constants, codes and the sine lookup for the image rotator
// no dependencies; imported by nearest_neighbor_image_rotator
package nnir_pkg;

    // source image and display geometry
    localparam int BG_SIZE        = 512;
    localparam int DISPLAY_WIDTH  = 320;
    localparam int DISPLAY_HEIGHT = 240;
    localparam int BG_W           = $clog2(BG_SIZE);
    localparam int MEM_DEPTH      = BG_SIZE * BG_SIZE;
    localparam int ADDR_W         = $clog2(MEM_DEPTH);

    // fixed point datapath
    localparam int FRAC_BITS = 14;
    localparam int TRIG_W    = 16;   // signed q1.14, -16384..16384
    localparam int FX_W      = 10;   // column offset, -511..511
    localparam int FY_W      = 9;    // row offset, -255..255
    localparam int PROD_W    = 25;
    localparam int SUM_W     = 26;
    localparam int POS_W     = 13;   // rotated source coordinate, signed

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_COL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_ROW = 2'd2;
    localparam int CFG_DATA_W = 9;

    localparam logic [8:0] ANGLE_RST     = 9'd0;
    localparam logic [8:0] PIVOT_COL_RST = 9'(DISPLAY_WIDTH / 2);
    localparam logic [7:0] PIVOT_ROW_RST = 8'(DISPLAY_HEIGHT / 2);

    // round(16384 * sin(k deg)), k = 0..90
    localparam logic [14:0] QUARTER_SINE [0:90] = '{
            15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
            15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
            15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
            15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
            15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
            15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
            15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
            15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
            15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
            15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
            15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
            15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
            15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
            15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
            15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
            15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
            15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
            15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
            15'd16384
        };

    // fold a 0..719 degree angle into 0..359 range, 360 and up wrap once
    function automatic logic [8:0] wrap_deg(input logic [9:0] deg);
        logic [9:0] red;
        red = (deg >= 10'd360) ? (deg - 10'd360) : deg;
        return red[8:0];
    endfunction

    // sine of a whole degree angle in 0..359, signed q1.14
    function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [8:0] deg);
        logic [8:0]  idx_full;
        logic        neg;
        logic [14:0] mag;
        logic signed [TRIG_W-1:0] pos;
        if (deg < 9'd90) begin
            idx_full = deg;
            neg      = 1'b0;
        end else if (deg < 9'd180) begin
            idx_full = 9'd180 - deg;
            neg      = 1'b0;
        end else if (deg < 9'd270) begin
            idx_full = deg - 9'd180;
            neg      = 1'b1;
        end else begin
            idx_full = 9'd360 - deg;
            neg      = 1'b1;
        end
        mag = QUARTER_SINE[idx_full[6:0]];
        pos = $signed({1'b0, mag});
        return neg ? -pos : pos;
    endfunction

endpackage

// ===== rtl/nearest_neighbor_image_rotator.sv =====
// nearest_neighbor_image_rotator: rotated nearest-neighbor sampling of a stored source image
// depends on nnir_pkg (geometry, codes, sine table)
//
// usage
//   input channel (i_valid / o_stall) carries one word per item: a write word
//   (operation = write) stores load_pixel at (load_column, load_row) of the
//   source image, a fetch word (operation = fetch) asks for display pixel
//   (out_column, out_row). writes give no result; each fetch gives one
//   output word (o_valid / i_stall) with the sampled pixel and the inside flag.
//   configuration: i_cfg_we with i_cfg_index selects angle, pivot column or
//   pivot row; writes land at once. the user must write only while no word is
//   in flight; the block itself does not enforce this. throughput: one word per
//   cycle unless the output stalls. all words go through a four-stage pipe around
//   one single-port source memory; its one access (write or read) per word sets the rate.
//   a fetch passes stages 1, 2 and 3 and is shown on o_valid from the output register.
//   a stalled receiver holds the output register; the stages before it keep
//   filling until every stage is occupied, only then o_stall rises.
//   reset clears the pipe valid bits and restores angle 0 and the pivot to
//   the display center; the source memory is not cleared and must be loaded
//   by software before it is read.
//
module nearest_neighbor_image_rotator
    import nnir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_operation,
    input  logic [8:0]            i_load_column,
    input  logic [8:0]            i_load_row,
    input  logic [15:0]           i_load_pixel,
    input  logic [8:0]            i_out_column,
    input  logic [7:0]            i_out_row,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [15:0]           o_pixel_out,
    output logic                  o_inside_source,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [8:0] r_angle;
    logic [8:0] r_pivot_col;
    logic [7:0] r_pivot_row;

    // cosine and sine registers follow the angle register in the cycle after it changes
    logic signed [TRIG_W-1:0] r_cos, r_sin;
    logic signed [TRIG_W-1:0] n_cos, n_sin;
    logic [8:0]               deg_s;

    // stage 1: offsets from the pivot, write address
    logic                     r_v1, r_f1, r_we1;
    logic signed [FX_W-1:0]   r_fx1;
    logic signed [FY_W-1:0]   r_fy1;
    logic [ADDR_W-1:0]        r_waddr1;
    logic [15:0]              r_wpix1;

    // stage 2: rotation products
    logic                     r_v2, r_f2, r_we2;
    logic signed [PROD_W-1:0] r_pcx2, r_psy2, r_psx2, r_pcy2;
    logic [ADDR_W-1:0]        r_waddr2;
    logic [15:0]              r_wpix2;

    // stage 3: memory access
    logic                     r_v3, r_f3, r_we3, r_in3;
    logic [ADDR_W-1:0]        r_addr3;
    logic [15:0]              r_wpix3;

    // stage 4: output word, read data straight from the memory register
    logic                     r_v4, r_in4;
    logic [15:0]              r_rdata;

    logic [15:0] mem [0:MEM_DEPTH-1];

    logic rdy1, rdy2, rdy3, rdy4;
    logic accept;

    // backpressure: a stage moves when it is empty or its successor moves;
    // writes leave stage 3 without needing the output register
    assign rdy4   = !r_v4 || !i_stall;
    assign rdy3   = !r_v3 || !r_f3 || rdy4;
    assign rdy2   = !r_v2 || rdy3;
    assign rdy1   = !r_v1 || rdy2;
    assign o_stall = !rdy1;
    assign accept  = i_valid && rdy1;

    //--------------------------------------------------------------------
    // configuration and trig registers
    //--------------------------------------------------------------------
    always_comb begin
        deg_s = wrap_deg({1'b0, r_angle});
        n_sin = sine_q14(deg_s);
        n_cos = sine_q14(wrap_deg({1'b0, deg_s} + 10'd90));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle     <= ANGLE_RST;
            r_pivot_col <= PIVOT_COL_RST;
            r_pivot_row <= PIVOT_ROW_RST;
            r_cos       <= sine_q14(9'd90);
            r_sin       <= '0;
        end else begin
            r_cos <= n_cos;
            r_sin <= n_sin;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ANGLE:     r_angle     <= i_cfg_data;
                    CFG_PIVOT_COL: r_pivot_col <= i_cfg_data;
                    CFG_PIVOT_ROW: r_pivot_row <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    //--------------------------------------------------------------------
    // stage 1
    //--------------------------------------------------------------------
    logic n_we1;
    assign n_we1 = (i_operation == OP_WRITE)
                && (32'(i_load_column) < BG_SIZE) && (32'(i_load_row) < BG_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1     <= (i_operation == OP_FETCH);
            r_we1    <= n_we1;
            r_fx1    <= $signed({1'b0, i_out_column}) - $signed({1'b0, r_pivot_col});
            r_fy1    <= $signed({1'b0, i_out_row}) - $signed({1'b0, r_pivot_row});
            r_waddr1 <= ADDR_W'(ADDR_W'(i_load_row) * ADDR_W'(BG_SIZE)
                        + ADDR_W'(i_load_column));
            r_wpix1  <= i_load_pixel;
        end
    end

    //--------------------------------------------------------------------
    // stage 2: four products, one multiplier each
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_f2     <= r_f1;
            r_we2    <= r_we1;
            r_pcx2   <= PROD_W'(r_cos * r_fx1);
            r_psy2   <= PROD_W'(r_sin * r_fy1);
            r_psx2   <= PROD_W'(r_sin * r_fx1);
            r_pcy2   <= PROD_W'(r_cos * r_fy1);
            r_waddr2 <= r_waddr1;
            r_wpix2  <= r_wpix1;
        end
    end

    //--------------------------------------------------------------------
    // stage 3 entry: sums, truncation toward zero, bounds, read address
    //--------------------------------------------------------------------
    logic signed [SUM_W-1:0] sum_x, sum_y, bias_x, bias_y, tx, ty;
    logic signed [POS_W-1:0] sx, sy;
    logic                    in_src;
    logic [ADDR_W-1:0]       raddr;

    always_comb begin
        sum_x  = SUM_W'(r_pcx2) + SUM_W'(r_psy2);
        sum_y  = SUM_W'(r_pcy2) - SUM_W'(r_psx2);
        // negative sums get 2^14-1 added so the arithmetic shift rounds to zero
        bias_x = sum_x + $signed({{(SUM_W-FRAC_BITS){1'b0}}, {FRAC_BITS{sum_x[SUM_W-1]}}});
        bias_y = sum_y + $signed({{(SUM_W-FRAC_BITS){1'b0}}, {FRAC_BITS{sum_y[SUM_W-1]}}});
        tx     = bias_x >>> FRAC_BITS;
        ty     = bias_y >>> FRAC_BITS;
        sx     = $signed(tx[POS_W-1:0] + POS_W'(BG_SIZE / 2));
        sy     = $signed(ty[POS_W-1:0] + POS_W'(BG_SIZE / 2));
        in_src = !sx[POS_W-1] && !sy[POS_W-1]
              && (sx < $signed(POS_W'(BG_SIZE))) && (sy < $signed(POS_W'(BG_SIZE)));
        raddr  = ADDR_W'(ADDR_W'(sy[BG_W-1:0]) * ADDR_W'(BG_SIZE)
                 + ADDR_W'(sx[BG_W-1:0]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_f3    <= r_f2;
            r_we3   <= r_we2;
            r_in3   <= in_src;
            r_addr3 <= r_f2 ? raddr : r_waddr2;
            r_wpix3 <= r_wpix2;
        end
    end

    //--------------------------------------------------------------------
    // source memory: one access per word, in arrival order, so reads
    // always see every earlier write
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_v3 && rdy3) begin
            if (r_we3) begin
                mem[r_addr3] <= r_wpix3;
            end else if (r_f3) begin
                r_rdata <= mem[r_addr3];
            end
        end
    end

    //--------------------------------------------------------------------
    // stage 4: output register
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy4) begin
            r_v4 <= r_v3 && r_f3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3 && r_f3) begin
            r_in4 <= r_in3;
        end
    end

    assign o_valid         = r_v4;
    assign o_inside_source = r_in4;
    assign o_pixel_out     = r_in4 ? r_rdata : 16'h0000;

    //--------------------------------------------------------------------
    // assertions
    //--------------------------------------------------------------------
    // the input only stalls once every stage is full behind a stalled output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && i_stall))
        else $error("input stalled with an empty stage");

    // a fetch blocked at the memory stage keeps its address
    a_fetch_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_f3 && !rdy4) |=> (r_v3 && r_f3 && $stable(r_addr3)))
        else $error("blocked fetch lost at memory stage");

    // a fetch leaving the memory stage always reaches the output register
    a_fetch_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_f3 && rdy4) |=> r_v4)
        else $error("fetch dropped between memory and output");

endmodule
